// File: src/base64_stream_codec_top_assert.svh
// Assertion macros shared by the base64 stream codec modules.
`ifndef BASE64_STREAM_CODEC_TOP_ASSERT_SVH
`define BASE64_STREAM_CODEC_TOP_ASSERT_SVH

// Flag any cycle on which the condition holds.
`define B64_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("base64 codec: forbidden condition seen");

// Require the consequent in the same cycle as the antecedent.
`define B64_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("base64 codec: implication violated");

// Require the consequent in the cycle after the antecedent.
`define B64_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("base64 codec: next-cycle check violated");

`endif

// File: src/b64_pkg.sv
// Types, constants and character tables for the base64 stream codec.
package b64_pkg;

   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam logic [5:0] SEXTET_MASK = 6'h3F;
   localparam logic [5:0] SEXTET_PLUS = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } b64_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       out_error;
   } b64_rsp_type;

   // Kind of work handed from the front to the back.
   typedef enum logic [1:0] {
      GRP_ENCODE,
      GRP_DECODE,
      GRP_ERROR
   } grp_op_type;

   // One finished group: encode holds the left-aligned bytes and the byte count,
   // decode holds the three bytes and how many of them to keep.
   typedef struct packed {
      grp_op_type  op;
      logic [23:0] bits;
      logic [1:0]  cnt;
      logic        last;
   } grp_type;

   // Map a sextet to its alphabet character.
   function automatic logic [7:0] alphabet_char(input logic [5:0] s);
      logic [7:0] ch;
      case (s) inside
         [6'd0:6'd25]:  ch = 8'(8'h41 + {2'b00, s});
         [6'd26:6'd51]: ch = 8'(8'h61 + {2'b00, s} - 8'd26);
         [6'd52:6'd61]: ch = 8'(8'h30 + {2'b00, s} - 8'd52);
         SEXTET_PLUS:   ch = 8'h2B;
         default:       ch = 8'h2F;
      endcase
      return ch;
   endfunction

   // Map a character to its sextet; anything outside the alphabet gives zero.
   function automatic logic [5:0] sextet_of(input logic [7:0] ch);
      logic [5:0] s;
      case (ch) inside
         [8'h41:8'h5A]: s = 6'(ch - 8'h41);
         [8'h61:8'h7A]: s = 6'(ch - 8'h61 + 8'd26);
         [8'h30:8'h39]: s = 6'(ch - 8'h30 + 8'd52);
         8'h2B:         s = SEXTET_PLUS;
         8'h2F:         s = SEXTET_SLASH;
         default:       s = 6'd0;
      endcase
      return s & SEXTET_MASK;
   endfunction

endpackage

// File: src/base64_stream_codec_top.sv
// Base64 stream codec: encodes bytes to characters or decodes characters to bytes.
//
// Use: csr_we/csr_wdata set the direction (0 encode, 1 decode) while the block is
// idle; every write also clears any partly collected group. Items enter on
// req_valid/req_data and are taken at an edge where req_stall is low; results
// leave on rsp_valid/rsp_data and are taken at an edge where rsp_stall is low.
// The front collects one item per cycle into a group while req_stall is low; a
// closed group goes into a short queue and the back expands it into results, one
// per cycle while rsp_stall allows, through an output register. The item that
// closes a group is written into the queue, and its first result then leaves
// through the output register. Input takes one item per cycle while the queue has
// room; when encoding, the back's one-result-per-cycle output sets the sustained rate.
// req_stall rises only when the queue is full. When the receiver holds
// rsp_stall, the output holds its item and the queue fills, then the input
// stalls. Reset (synchronous, active high) selects encode, empties the queue
// and clears the group state.
module base64_stream_codec_top
   import b64_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  b64_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output b64_rsp_type rsp_data
);

   logic    accept;
   logic    push;
   grp_type push_grp;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   grp_type head_grp;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   b64_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .push_grp (push_grp)
   );

   b64_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_grp(push_grp),
      .pop     (pop),
      .full    (q_full),
      .empty   (q_empty),
      .head_grp(head_grp)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(!q_empty),
      .head_grp  (head_grp),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/b64_front.sv
// Front end: accepts items, collects groups and hands finished groups on.
module b64_front
   import b64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        accept,
   input  b64_req_type req_data,
   output logic        push,
   output grp_type     push_grp
);

   logic        mode_ff, mode_in;
   logic [23:0] group_ff, group_in;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  pad_ff, pad_in;

   logic [23:0] enc_buf;
   logic [23:0] dec_buf;
   logic [1:0]  pad_next;
   logic [1:0]  keep;

   assign enc_buf  = {group_ff[15:0], req_data.in_byte};
   assign dec_buf  = {group_ff[17:0], sextet_of(req_data.in_byte)};
   assign pad_next = (req_data.in_byte == PAD_CHAR && pad_ff != 2'd3) ?
                     2'(pad_ff + 2'd1) : pad_ff;
   assign keep     = 2'(2'd3 - pad_next);

   // Collect the group and emit a descriptor when it closes (a quad of three or more pads: only if last).
   always_comb begin
      mode_in  = mode_ff;
      group_in = group_ff;
      count_in = count_ff;
      pad_in   = pad_ff;
      push     = 1'b0;
      push_grp = '{op: GRP_ERROR, bits: 24'd0, cnt: 2'd0, last: 1'b1};
      if (csr_we) begin
         mode_in  = csr_wdata;
         group_in = 24'd0;
         count_in = 2'd0;
         pad_in   = 2'd0;
      end else if (accept) begin
         if (!mode_ff) begin
            if (count_ff < 2'd2 && !req_data.in_last) begin
               group_in = enc_buf;
               count_in = 2'(count_ff + 2'd1);
            end else begin
               push          = 1'b1;
               push_grp.op   = GRP_ENCODE;
               push_grp.last = req_data.in_last;
               case (count_ff)
                  2'd0: begin
                     push_grp.bits = {enc_buf[7:0], 16'd0};
                     push_grp.cnt  = 2'd1;
                  end
                  2'd1: begin
                     push_grp.bits = {enc_buf[15:0], 8'd0};
                     push_grp.cnt  = 2'd2;
                  end
                  default: begin
                     push_grp.bits = enc_buf;
                     push_grp.cnt  = 2'd3;
                  end
               endcase
               group_in = 24'd0;
               count_in = 2'd0;
               pad_in   = 2'd0;
            end
         end else begin
            if (count_ff != 2'd3) begin
               if (req_data.in_last) begin
                  push     = 1'b1;
                  group_in = 24'd0;
                  count_in = 2'd0;
                  pad_in   = 2'd0;
               end else begin
                  group_in = dec_buf;
                  count_in = 2'(count_ff + 2'd1);
                  pad_in   = pad_next;
               end
            end else begin
               // Quad complete: keep the bytes not cancelled by padding.
               if (keep == 2'd0) begin
                  push = req_data.in_last;
               end else begin
                  push          = 1'b1;
                  push_grp.op   = GRP_DECODE;
                  push_grp.bits = dec_buf;
                  push_grp.cnt  = keep;
                  push_grp.last = req_data.in_last;
               end
               group_in = 24'd0;
               count_in = 2'd0;
               pad_in   = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         group_ff <= 24'd0;
         count_ff <= 2'd0;
         pad_ff   <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         group_ff <= group_in;
         count_ff <= count_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

// File: src/b64_queue.sv
// Short group queue between the front and the back.
module b64_queue
   import b64_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  grp_type push_grp,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output grp_type head_grp
);

`include "base64_stream_codec_top_assert.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   grp_type              slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_grp = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed groups.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_grp;
      end
   end

   `B64_ASSERT_NEVER(a_no_overflow, push && full)
   `B64_ASSERT_NEVER(a_no_underflow, pop && empty)
   `B64_ASSERT_NEXT(a_count_up, push && !pop, count_ff == CNT_W'($past(count_ff) + 1'b1))

endmodule

// File: src/b64_back.sv
// Back end: expands each group into result items through an output register.
module b64_back
   import b64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  grp_type     head_grp,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output b64_rsp_type rsp_data
);

`include "base64_stream_codec_top_assert.svh"

   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   b64_rsp_type rsp_data_ff, rsp_data_in;

   logic        out_load;
   logic [5:0]  sextet;
   logic [7:0]  dec_byte;
   logic        final_item;
   b64_rsp_type item;

   assign out_load = !rsp_valid_ff || !rsp_stall;

   // Select the sextet and byte for the current position.
   always_comb begin
      case (idx_ff)
         2'd0:    sextet = head_grp.bits[23:18];
         2'd1:    sextet = head_grp.bits[17:12];
         2'd2:    sextet = head_grp.bits[11:6];
         default: sextet = head_grp.bits[5:0];
      endcase
      case (idx_ff)
         2'd0:    dec_byte = head_grp.bits[23:16];
         2'd1:    dec_byte = head_grp.bits[15:8];
         default: dec_byte = head_grp.bits[7:0];
      endcase
   end

   // Build the result item and decide whether the group is done.
   always_comb begin
      case (head_grp.op)
         GRP_ENCODE: begin
            final_item     = (idx_ff == 2'd3);
            item.out_byte  = (idx_ff <= head_grp.cnt) ? alphabet_char(sextet) : PAD_CHAR;
            item.out_last  = final_item && head_grp.last;
            item.out_error = 1'b0;
         end
         GRP_DECODE: begin
            final_item     = (idx_ff == 2'(head_grp.cnt - 2'd1));
            item.out_byte  = dec_byte;
            item.out_last  = final_item && head_grp.last;
            item.out_error = 1'b0;
         end
         default: begin
            final_item     = 1'b1;
            item.out_byte  = 8'd0;
            item.out_last  = 1'b1;
            item.out_error = 1'b1;
         end
      endcase
   end

   // Load the output register when it is free or being taken.
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      if (out_load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_data_in = item;
            pop         = final_item;
            idx_in      = final_item ? 2'd0 : 2'(idx_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `B64_ASSERT_IMPLIES(a_error_is_last, rsp_valid_ff && rsp_data_ff.out_error,
                       rsp_data_ff.out_last)

endmodule

// File: tb/sv/base64_stream_codec_top_test.sv
// Self-checking testbench for the base64 stream codec: directed table, then random traffic.
module base64_stream_codec_top_test;
   import b64_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;
   localparam int   SETTLE_CYCLES = 8;
   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // How a directed row gets its expected results
   typedef enum logic [1:0] {
      BY_PREDICTOR,
      TYPED_CHARS,
      TYPED_ERROR
   } row_check_type;

   typedef struct packed {
      logic          mode;
      logic [7:0]    ch;
      logic          last;
      row_check_type chk;
      logic [31:0]   typed;
   } stim_row_type;

   // Directed items: extremes, padding, bad characters, partial quads
   localparam stim_row_type DIRECTED [25] = '{
      '{MODE_ENCODE, 8'h00, 1'b1, TYPED_CHARS,  "AA=="},
      '{MODE_ENCODE, 8'hFF, 1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_ENCODE, 8'hFF, 1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_ENCODE, 8'hFF, 1'b1, TYPED_CHARS,  "////"},
      '{MODE_ENCODE, 8'hFF, 1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_ENCODE, 8'h00, 1'b1, BY_PREDICTOR, 32'h0},
      '{MODE_ENCODE, 8'h5A, 1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "T",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "W",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "F",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "u",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "=",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "A",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "=",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "=",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "=",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "=",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "=",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "=",   1'b1, TYPED_ERROR,  32'h0},
      '{MODE_DECODE, 8'h00, 1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "+",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "=",   1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "/",   1'b1, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, 8'hFF, 1'b0, BY_PREDICTOR, 32'h0},
      '{MODE_DECODE, "a",   1'b1, TYPED_ERROR,  32'h0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   b64_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   b64_rsp_type rsp_data;

   // Codec state as the predictor sees it
   logic        cur_mode = MODE_ENCODE;
   logic [23:0] grp_bits = '0;
   logic [1:0]  grp_fill = '0;
   logic [1:0]  pad_seen = '0;

   b64_rsp_type pending_rsp [$];
   bit          idle_en = 1'b1;
   int          items_sent = 0;
   int          rsp_seen = 0;
   int          mode_writes = 0;
   int          mismatch_count = 0;

   base64_stream_codec_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic b64_rsp_type make_rsp(input logic [7:0] b, input logic l,
                                            input logic e);
      b64_rsp_type r;
      r.out_byte  = b;
      r.out_last  = l;
      r.out_error = e;
      return r;
   endfunction

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      return ALPHABET[8*(63 - int'(s)) +: 8];
   endfunction

   // Search the alphabet; anything not found maps to zero
   function automatic logic [5:0] char_sextet(input logic [7:0] ch);
      for (int i = 0; i < 64; i++) begin
         if (sextet_char(6'(i)) == ch) return 6'(i);
      end
      return 6'd0;
   endfunction

   function automatic void clear_group();
      grp_bits = '0;
      grp_fill = '0;
      pad_seen = '0;
   endfunction

   // Advance the codec state by one item and return the results it causes
   function automatic int codec_step(input b64_req_type it, output b64_rsp_type [3:0] res);
      int          n;
      int          keep;
      logic [23:0] v;
      logic [7:0]  ch;
      res = '0;
      n = int'(grp_fill) + 1;
      if (cur_mode == MODE_ENCODE) begin
         grp_bits = {grp_bits[15:0], it.in_byte};
         if (n < 3 && !it.in_last) begin
            grp_fill = 2'(n);
            return 0;
         end
         v = grp_bits << (8 * (3 - n));
         for (int k = 0; k < 4; k++) begin
            ch = (k <= n) ? sextet_char(v[23 - 6*k -: 6]) : PAD_CHAR;
            res[k] = make_rsp(ch, (k == 3) ? it.in_last : 1'b0, 1'b0);
         end
         clear_group();
         return 4;
      end
      grp_bits = {grp_bits[17:0], char_sextet(it.in_byte)};
      if (it.in_byte == PAD_CHAR && pad_seen < 2'd3) pad_seen++;
      if (n < 4) begin
         if (it.in_last) begin
            clear_group();
            res[0] = make_rsp(8'h00, 1'b1, 1'b1);
            return 1;
         end
         grp_fill = 2'(n);
         return 0;
      end
      keep = 3 - int'(pad_seen);
      if (keep == 0) begin
         clear_group();
         if (it.in_last) begin
            res[0] = make_rsp(8'h00, 1'b1, 1'b1);
            return 1;
         end
         return 0;
      end
      for (int k = 0; k < keep; k++) begin
         res[k] = make_rsp(grp_bits[23 - 8*k -: 8], (k + 1 == keep) ? it.in_last : 1'b0,
                           1'b0);
      end
      clear_group();
      return keep;
   endfunction

   // Offer one item, hold it until taken, then queue what it should produce
   task automatic push_item(input logic [7:0] ch, input logic last,
                            input row_check_type chk, input logic [31:0] typed);
      b64_req_type      it;
      b64_rsp_type [3:0] res;
      int               n;
      it.in_byte = ch;
      it.in_last = last;
      if (idle_en) begin
         while ($urandom_range(99) < 7) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      n = codec_step(it, res);
      case (chk)
         TYPED_CHARS: begin
            for (int k = 0; k < 4; k++)
               pending_rsp.push_back(make_rsp(typed[31 - 8*k -: 8],
                                              (k == 3) ? last : 1'b0, 1'b0));
         end
         TYPED_ERROR: pending_rsp.push_back(make_rsp(8'h00, 1'b1, 1'b1));
         default: begin
            for (int k = 0; k < n; k++) pending_rsp.push_back(res[k]);
         end
      endcase
   endtask

   // Drop valid and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Write the direction register once the block has gone quiet
   task automatic set_mode(input logic m);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we   <= 1'b0;
      cur_mode = m;
      clear_group();
      mode_writes++;
   endtask

   // Check each accepted result against the oldest expectation; randomize stall
   always @(posedge clock) begin : rsp_check
      b64_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing expected, got byte %02h last %0b err %0b",
                     $time, rsp_data.out_byte, rsp_data.out_last, rsp_data.out_error);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.out_last !== want.out_last ||
                rsp_data.out_error !== want.out_error) begin
               mismatch_count++;
               $display("%0t: expected byte %02h last %0b err %0b, got %02h %0b %0b",
                        $time, want.out_byte, want.out_last, want.out_error,
                        rsp_data.out_byte, rsp_data.out_last, rsp_data.out_error);
            end
         end
      end
      rsp_stall <= idle_en && ($urandom_range(99) < 7);
   end

   // Stimulus
   initial begin
      logic [7:0] msg [$];
      logic       m;
      int         n_items;
      int         nq;
      int         pads;
      int         len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < $size(DIRECTED); i++) begin
         if (DIRECTED[i].mode != cur_mode) set_mode(DIRECTED[i].mode);
         push_item(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].chk, DIRECTED[i].typed);
      end

      // Random phases; decode mostly gets well-formed messages
      for (int p = 0; p < 6; p++) begin
         m = (p % 3 == 0) ? MODE_ENCODE : MODE_DECODE;
         set_mode(m);
         idle_en = (p != 2);
         n_items = 0;
         while (n_items < 16) begin
            if (m == MODE_ENCODE) begin
               push_item(8'($urandom_range(255)), $urandom_range(5) == 0, BY_PREDICTOR, '0);
               n_items++;
               if (p == 0 && n_items == 10) drain_results();
            end else begin
               msg.delete();
               if ($urandom_range(99) < 75) begin
                  nq   = $urandom_range(1, 2);
                  pads = $urandom_range(0, 2);
                  for (int j = 0; j < 4 * nq; j++) begin
                     if (j >= 4 * nq - pads) msg.push_back(PAD_CHAR);
                     else msg.push_back(sextet_char(6'($urandom_range(63))));
                  end
               end else begin
                  len = $urandom_range(1, 6);
                  for (int j = 0; j < len; j++) begin
                     case ($urandom_range(3))
                        0:       msg.push_back(8'($urandom_range(255)));
                        1:       msg.push_back(PAD_CHAR);
                        default: msg.push_back(sextet_char(6'($urandom_range(63))));
                     endcase
                  end
               end
               foreach (msg[j]) begin
                  push_item(msg[j], j == msg.size() - 1, BY_PREDICTOR, '0);
                  n_items++;
               end
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d items in both directions over %0d mode writes; checked %0d results.",
               items_sent, mode_writes, rsp_seen);
      $display("Coverage: padding, bad characters, partial quads, stalls on both sides.");
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("base64_stream_codec_top_test: PASS");
      end else begin
         $display("base64_stream_codec_top_test: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("base64_stream_codec_top_test: FAIL");
      $finish;
   end

endmodule

// File: base64_stream_codec_top.f
+incdir+src
src/b64_pkg.sv
src/b64_front.sv
src/b64_queue.sv
src/b64_back.sv
src/base64_stream_codec_top.sv
tb/sv/base64_stream_codec_top_test.sv
